/* hdl/pvm_pkg.sv */
`default_nettype none

package pvm_pkg;

    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int AMP_W       = 15;
    localparam int HALF_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int SHOWN_W     = 4;
    localparam int SHOWN_MAX   = 15;
    localparam int NOTE_COUNT  = 128;
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int SCALE_W     = VEL_W + AMP_W;
    localparam int SCALE_RND   = 63;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd8454661;
    localparam int RECIP_SHIFT = 30;
    localparam int PROD_W      = SCALE_W + 1 + RECIP_W;

    localparam logic [AMP_W-1:0]           AMP_MAX_RST = 15'd8191;
    localparam logic signed [SAMPLE_W-1:0] CEIL_RST    = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] FLOOR_RST   = -16'sd32768;
    localparam logic signed [SAMPLE_W-1:0] SILENCE_RST = 16'sd0;

    localparam logic [CFG_ADDR_W-1:0] CFG_AMP_MAX = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SILENCE = 2'd3;

    localparam longint unsigned HALF_DEN_BASE = 64'd880000000000;
    localparam longint unsigned SEMI_RATIO [12] = '{
        64'd1000000000, 64'd943874313, 64'd890898718, 64'd840896415,
        64'd793700526,  64'd749153538, 64'd707106781, 64'd667419927,
        64'd629960525,  64'd594603558, 64'd561231024, 64'd529731547
    };

    typedef enum logic [1:0] {
        FN_NOTE_ON  = 2'd0,
        FN_NOTE_OFF = 2'd1,
        FN_TICK     = 2'd2,
        FN_NONE     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RECIP,
        ST_LAUNCH,
        ST_CHAIN,
        ST_MIX,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        func_t             func;
        logic [NOTE_W-1:0] note;
        logic [AMP_W-1:0]  amp;
        logic [HALF_W-1:0] half;
        logic              start_ok;
        logic              found;
        logic              claimed;
    } tok_t;

endpackage

`default_nettype wire

/* hdl/pvm_voice_cell.sv */
`default_nettype none

module pvm_voice_cell
    import pvm_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int CNT_W = 4
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tok_t                    tok_in,
    input  wire logic signed [SUM_W-1:0] sum_in,
    input  wire logic [CNT_W-1:0]        cnt_in,
    output tok_t                         tok_out,
    output logic signed [SUM_W-1:0]      sum_out,
    output logic [CNT_W-1:0]             cnt_out
);

    logic              on_reg, on_next;
    logic [NOTE_W-1:0] note_reg, note_next;
    logic [AMP_W-1:0]  amp_reg, amp_next;
    logic [HALF_W-1:0] half_reg, half_next;
    logic [HALF_W-1:0] cd_reg, cd_next;
    logic              neg_reg, neg_next;

    tok_t                    tok_reg, tok_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic                    match;
    logic                    claim;
    logic                    sounding;
    logic                    neg_tick;
    logic [HALF_W-1:0]       cd_tick;
    logic signed [SUM_W-1:0] amp_x;
    logic signed [SUM_W-1:0] level;

    always_comb
    begin
        match    = on_reg && (note_reg == tok_in.note) && !tok_in.found;
        claim    = (tok_in.func == FN_NOTE_ON) && tok_in.start_ok && !tok_in.claimed
                   && (!on_reg || match);
        sounding = tok_in.valid && (tok_in.func == FN_TICK) && on_reg;
        neg_tick = (cd_reg == '0) ? !neg_reg : neg_reg;
        cd_tick  = (cd_reg == '0) ? half_reg - HALF_W'(1) : cd_reg - HALF_W'(1);
        amp_x    = SUM_W'({1'b0, amp_reg});
        level    = neg_tick ? -amp_x : amp_x;
    end

    always_comb
    begin
        on_next   = on_reg;
        note_next = note_reg;
        amp_next  = amp_reg;
        half_next = half_reg;
        cd_next   = cd_reg;
        neg_next  = neg_reg;
        if (tok_in.valid)
        begin
            case (tok_in.func)
                FN_NOTE_ON:
                begin
                    if (claim)
                    begin
                        on_next   = 1'b1;
                        note_next = tok_in.note;
                        amp_next  = tok_in.amp;
                        half_next = tok_in.half;
                        cd_next   = tok_in.half;
                        neg_next  = 1'b0;
                    end
                    else if (match)
                    begin
                        on_next = 1'b0;
                    end
                end
                FN_NOTE_OFF:
                begin
                    if (match)
                    begin
                        on_next = 1'b0;
                    end
                end
                FN_TICK:
                begin
                    if (on_reg)
                    begin
                        neg_next = neg_tick;
                        cd_next  = cd_tick;
                    end
                end
                default:
                begin
                    on_next = on_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        tok_next         = tok_in;
        tok_next.found   = tok_in.found || match;
        tok_next.claimed = tok_in.claimed || claim;
        sum_next         = sounding ? sum_in + level : sum_in;
        cnt_next         = sounding ? cnt_in + CNT_W'(1) : cnt_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg  <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            on_reg  <= on_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
        amp_reg  <= amp_next;
        half_reg <= half_next;
        cd_reg   <= cd_next;
        neg_reg  <= neg_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

/* hdl/pvm_divider.sv */
`default_nettype none

module pvm_divider
#(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5,
    parameter int QUO_W = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [QUO_W-1:0]      quo
);

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(QUO_W);
            rem_next  = DEN_W'(num >> QUO_W);
            den_next  = den;
            quo_next  = num[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

/* hdl/polyphonic_square_voice_mixer_core.sv */
// Pool of VOICES square-wave voices driven by note-on, note-off and sample-tick
// transactions (kind on s_tuser), one transaction at a time. Each voice lives in
// one cell of a chain; a command token walks the chain one cell per cycle, and a
// note-on first passes the velocity scaling multiplies (ST_SCALE, then ST_RECIP).
// For a tick the chain walk sums the active levels, then a 16-step rounding
// divider forms the average; a silent or clamped tick skips the divider. An
// unused kind is accepted and dropped. Only ticks produce an output transaction
// (sample in bits 15:0, sounding voice count in bits 19:16); a finished sample
// waits in the output register while the next command is taken, and a tick that
// finds that register still full holds until it drains.
// Configuration writes must only be issued while the block is idle.
`default_nettype none

module polyphonic_square_voice_mixer_core
    import pvm_pkg::*;
#(
    parameter int VOICES     = 8,
    parameter int AUDIO_RATE = 44100
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // note[6:0], velocity[13:7]
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // func[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // sample[15:0], voices_sounding[19:16]
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W = 17 + $clog2(VOICES);
    localparam int CNT_W = $clog2(VOICES + 1);
    localparam int CMP_W = SUM_W + 2;
    localparam int NUM_W = SUM_W + 1;
    localparam int DEN_W = CNT_W + 1;

    state_t state_reg, state_next;

    logic [AMP_W-1:0]           amp_max_reg;
    logic signed [SAMPLE_W-1:0] ceil_reg;
    logic signed [SAMPLE_W-1:0] floor_reg;
    logic signed [SAMPLE_W-1:0] silence_reg;

    func_t             func_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic [SCALE_W-1:0] prod1_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [SAMPLE_W-1:0] res_reg;
    logic                       m_valid_reg;
    logic [OUT_DATA_W-1:0]      m_data_reg;

    logic [HALF_W-1:0] half_rom [NOTE_COUNT];

    tok_t                    tok_chain [VOICES+1];
    logic signed [SUM_W-1:0] sum_chain [VOICES+1];
    logic [CNT_W-1:0]        cnt_chain [VOICES+1];

    logic                       accept;
    logic                       launch;
    logic                       div_start;
    logic                       out_load;
    logic                       tail_valid;
    logic [AMP_W-1:0]           amp_calc;
    logic [SCALE_W:0]           scale_rnd;
    logic signed [CMP_W-1:0]    sum_x;
    logic signed [CMP_W-1:0]    cnt_x;
    logic signed [CMP_W-1:0]    ceil_lim;
    logic signed [CMP_W-1:0]    floor_lim;
    logic                       cnt_zero;
    logic                       over_ceil;
    logic                       under_floor;
    logic [SUM_W-1:0]           mag;
    logic [NUM_W-1:0]           div_num;
    logic [DEN_W-1:0]           div_den;
    logic                       div_done;
    logic [SAMPLE_W-1:0]        div_quo;
    logic [SHOWN_W-1:0]         shown;

    // Half-period table, built at elaboration
    for (genvar n = 0; n < NOTE_COUNT; n++)
    begin : g_half
        localparam int K   = n + 3;
        localparam int OCT = K / 12 - 6;
        localparam longint unsigned NUM0 = longint'(AUDIO_RATE) * SEMI_RATIO[K % 12];
        localparam longint unsigned HNUM = NUM0 << ((OCT < 0) ? -OCT : 0);
        localparam longint unsigned HDEN = HALF_DEN_BASE << ((OCT < 0) ? 0 : OCT);
        localparam longint unsigned HRAW = (2 * HNUM + HDEN) / (2 * HDEN);
        localparam longint unsigned HCLP = (HRAW < 1) ? 1 : ((HRAW > 65535) ? 65535 : HRAW);
        assign half_rom[n] = HALF_W'(HCLP);
    end

    // Voice chain
    assign tok_chain[0] = '{
        valid:    launch,
        func:     func_reg,
        note:     note_reg,
        amp:      amp_calc,
        half:     half_rom[note_reg],
        start_ok: (note_reg != '0) && (amp_calc != '0),
        found:    1'b0,
        claimed:  1'b0
    };
    assign sum_chain[0] = '0;
    assign cnt_chain[0] = '0;

    for (genvar v = 0; v < VOICES; v++)
    begin : g_cell
        pvm_voice_cell #(
            .SUM_W (SUM_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[v]),
            .sum_in  (sum_chain[v]),
            .cnt_in  (cnt_chain[v]),
            .tok_out (tok_chain[v+1]),
            .sum_out (sum_chain[v+1]),
            .cnt_out (cnt_chain[v+1])
        );
    end

    assign tail_valid = tok_chain[VOICES].valid;

    // Rounding average
    pvm_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (SAMPLE_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        amp_calc    = prod2_reg[RECIP_SHIFT+AMP_W-1:RECIP_SHIFT];
        scale_rnd   = (SCALE_W+1)'(prod1_reg) + (SCALE_W+1)'(SCALE_RND);
        sum_x       = CMP_W'(sum_reg);
        cnt_x       = CMP_W'({1'b0, cnt_reg});
        ceil_lim    = CMP_W'(ceil_reg) * cnt_x;
        floor_lim   = CMP_W'(floor_reg) * cnt_x;
        cnt_zero    = (cnt_reg == '0);
        over_ceil   = sum_x > ceil_lim;
        under_floor = sum_x < floor_lim;
        mag         = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_num     = {mag, 1'b0} + NUM_W'(cnt_reg);
        div_den     = {cnt_reg, 1'b0};
        shown       = (int'(cnt_reg) > SHOWN_MAX) ? SHOWN_W'(SHOWN_MAX) : SHOWN_W'(cnt_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (func_t'(s_tuser))
                        FN_NOTE_ON:  state_next = ST_SCALE;
                        FN_NOTE_OFF: state_next = ST_LAUNCH;
                        FN_TICK:     state_next = ST_LAUNCH;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE:  state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_CHAIN;
            ST_CHAIN:
            begin
                if (tail_valid)
                begin
                    state_next = (func_reg == FN_TICK) ? ST_MIX : ST_IDLE;
                end
            end
            ST_MIX:
            begin
                if (cnt_zero || over_ceil || under_floor)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready  = 1'b0;
        launch    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_LAUNCH: launch    = 1'b1;
            ST_MIX:    div_start = !(cnt_zero || over_ceil || under_floor);
            ST_DONE:   out_load  = !m_valid_reg || m_tready;
            default:   s_tready  = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            amp_max_reg <= AMP_MAX_RST;
            ceil_reg    <= CEIL_RST;
            floor_reg   <= FLOOR_RST;
            silence_reg <= SILENCE_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_AMP_MAX: amp_max_reg <= cfg_data[AMP_W-1:0];
                    CFG_CEILING: ceil_reg    <= $signed(cfg_data);
                    CFG_FLOOR:   floor_reg   <= $signed(cfg_data);
                    CFG_SILENCE: silence_reg <= $signed(cfg_data);
                    default:     amp_max_reg <= amp_max_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(s_tuser);
            note_reg <= s_tdata[NOTE_W-1:0];
            vel_reg  <= s_tdata[NOTE_W+VEL_W-1:NOTE_W];
        end
        if (state_reg == ST_SCALE)
        begin
            prod1_reg <= SCALE_W'(vel_reg) * SCALE_W'(amp_max_reg);
        end
        if (state_reg == ST_RECIP)
        begin
            prod2_reg <= PROD_W'(scale_rnd) * PROD_W'(RECIP_MUL);
        end
        if (tail_valid)
        begin
            sum_reg <= sum_chain[VOICES];
            cnt_reg <= cnt_chain[VOICES];
        end
        if (state_reg == ST_MIX)
        begin
            if (cnt_zero)
            begin
                res_reg <= silence_reg;
            end
            else if (over_ceil)
            begin
                res_reg <= ceil_reg;
            end
            else
            begin
                res_reg <= floor_reg;
            end
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            res_reg <= sum_reg[SUM_W-1] ? $signed(-div_quo) : $signed(div_quo);
        end
        if (out_load)
        begin
            m_data_reg <= OUT_DATA_W'({shown, res_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* hdl/pvm_checker.sv */
`default_nettype none

module pvm_checker
    import pvm_pkg::*;
#(
    parameter int VOICES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    // Stay busy after taking a command
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != FN_NONE) |=> !s_tready)
        else $error("input accepted while a command is in flight");

    // A tick never yields its sample in the next cycle
    a_no_early_sample: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FN_TICK) && !m_tvalid |=> !m_tvalid)
        else $error("sample appeared before the voice chain was walked");

    // Never report more voices than the pool holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[19:16]) <= VOICES))
        else $error("sounding voice count exceeds pool size");

endmodule

bind polyphonic_square_voice_mixer_core pvm_checker #(.VOICES(VOICES)) u_pvm_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb
    import pvm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL          = 8;
    localparam int RATE_HZ       = 44100;
    localparam int SETTLE_CYCLES = 48;
    localparam int SEG_ITEMS     = 55;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [SHOWN_W-1:0]         voices;
    } mix_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // mixer shadow: configuration and voice pool
    logic [AMP_W-1:0]           amp_max;
    logic signed [SAMPLE_W-1:0] ceil_lvl;
    logic signed [SAMPLE_W-1:0] floor_lvl;
    logic signed [SAMPLE_W-1:0] silence_lvl;
    logic [POOL-1:0]            voice_on;
    logic [NOTE_W-1:0]          voice_note [POOL];
    logic signed [SAMPLE_W-1:0] voice_amp  [POOL];
    logic signed [SAMPLE_W-1:0] voice_lvl  [POOL];
    logic [HALF_W-1:0]          voice_half [POOL];
    logic [HALF_W-1:0]          voice_down [POOL];

    mix_out_t expected_mix [$];
    int       mismatches;
    int       cycle_count;
    int       sender_idle_pct;
    int       stall_pct;
    int       hold_left;

    polyphonic_square_voice_mixer_core #(
        .VOICES     (POOL),
        .AUDIO_RATE (RATE_HZ)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready = 1'b0;
        end
        else
            m_tready = ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [HALF_W-1:0] half_period_for(logic [NOTE_W-1:0] n);
        int unsigned       k;
        int                oct;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   h;
        k   = n + 3;
        oct = int'(k / 12) - 6;
        num = longint'(RATE_HZ) * SEMI_RATIO[k % 12];
        den = HALF_DEN_BASE;
        if (oct < 0)
            num = num << (-oct);
        else
            den = den << oct;
        h = (2 * num + den) / (2 * den);
        if (h < 1)
            h = 1;
        if (h > 65535)
            h = 65535;
        return h[HALF_W-1:0];
    endfunction

    function automatic int find_voice(logic [NOTE_W-1:0] n);
        for (int i = 0; i < POOL; i++)
            if (voice_on[i] && voice_note[i] == n)
                return i;
        return -1;
    endfunction

    function automatic mix_out_t mix_tick();
        longint   total;
        longint   count;
        longint   mag;
        longint   res;
        mix_out_t o;
        total = 0;
        count = 0;
        for (int i = 0; i < POOL; i++)
        begin
            if (voice_on[i])
            begin
                count++;
                if (voice_down[i] == 0)
                begin
                    voice_lvl[i]  = (voice_lvl[i] == voice_amp[i]) ? -voice_amp[i] : voice_amp[i];
                    voice_down[i] = voice_half[i];
                end
                if (voice_down[i] != 0)
                    voice_down[i] = voice_down[i] - 1;
                total += voice_lvl[i];
            end
        end
        if (count == 0)
            res = silence_lvl;
        else if (total > longint'(ceil_lvl) * count)
            res = ceil_lvl;
        else if (total < longint'(floor_lvl) * count)
            res = floor_lvl;
        else
        begin
            mag = (total < 0) ? -total : total;
            res = (2 * mag + count) / (2 * count);
            if (total < 0)
                res = -res;
        end
        o.sample = res[SAMPLE_W-1:0];
        o.voices = (count > SHOWN_MAX) ? SHOWN_MAX[SHOWN_W-1:0] : count[SHOWN_W-1:0];
        return o;
    endfunction

    function automatic void apply_command(func_t f, logic [NOTE_W-1:0] n,
                                          logic [VEL_W-1:0] v);
        int          slot;
        int unsigned amp;
        case (f)
            FN_NOTE_ON:
            begin
                slot = find_voice(n);
                if (slot >= 0)
                    voice_on[slot] = 1'b0;
                amp = (2 * v * amp_max + 127) / 254;
                if (n == 0 || amp == 0)
                    return;
                slot = -1;
                for (int i = POOL - 1; i >= 0; i--)
                    if (!voice_on[i])
                        slot = i;
                if (slot < 0)
                    return;
                voice_on[slot]   = 1'b1;
                voice_note[slot] = n;
                voice_amp[slot]  = amp[SAMPLE_W-1:0];
                voice_lvl[slot]  = amp[SAMPLE_W-1:0];
                voice_half[slot] = half_period_for(n);
                voice_down[slot] = voice_half[slot];
            end
            FN_NOTE_OFF:
            begin
                slot = find_voice(n);
                if (slot >= 0)
                begin
                    voice_on[slot]  = 1'b0;
                    voice_lvl[slot] = '0;
                end
            end
            FN_TICK:
                expected_mix.push_back(mix_tick());
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        mix_out_t exp_o;
        mix_out_t got_o;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_o.sample = m_tdata[15:0];
            got_o.voices = m_tdata[19:16];
            if (expected_mix.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transaction sample %0d voices %0d",
                             $realtime, got_o.sample, got_o.voices);
            end
            else
            begin
                exp_o = expected_mix.pop_front();
                if (got_o.sample !== exp_o.sample || got_o.voices !== exp_o.voices)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: sample exp %0d got %0d, voices exp %0d got %0d",
                                 $realtime, exp_o.sample, got_o.sample,
                                 exp_o.voices, got_o.voices);
                end
            end
        end
    end

    task automatic send_cmd(func_t f, logic [NOTE_W-1:0] n, logic [VEL_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tdata  = {2'b00, v, n};
        do
            @(posedge clk);
        while (!s_tready);
        apply_command(f, n, v);
    endtask

    // drop valid, wait for every expected sample, then let the block settle
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_AMP_MAX: amp_max     = val[AMP_W-1:0];
            CFG_CEILING: ceil_lvl    = val;
            CFG_FLOOR:   floor_lvl   = val;
            CFG_SILENCE: silence_lvl = val;
            default: ;
        endcase
    endtask

    task automatic program_mixer(logic [AMP_W-1:0] amp, logic [15:0] ceil_v,
                                 logic [15:0] floor_v, logic [15:0] silence_v);
        drain();
        write_reg(CFG_AMP_MAX, {1'b0, amp});
        write_reg(CFG_CEILING, ceil_v);
        write_reg(CFG_FLOOR, floor_v);
        write_reg(CFG_SILENCE, silence_v);
    endtask

    task automatic release_all();
        while (|voice_on)
            for (int i = 0; i < POOL; i++)
                if (voice_on[i])
                    send_cmd(FN_NOTE_OFF, voice_note[i], '0);
    endtask

    task automatic test_directed();
        send_cmd(FN_TICK, 7'd0, 7'd0);
        send_cmd(FN_NOTE_ON, 7'd127, 7'd127);
        repeat (3) send_cmd(FN_TICK, 7'd127, 7'd127);
        send_cmd(FN_NOTE_ON, 7'd0, 7'd100);
        send_cmd(FN_NOTE_ON, 7'd60, 7'd0);
        send_cmd(FN_NOTE_ON, 7'd127, 7'd64);
        send_cmd(FN_NOTE_ON, 7'd1, 7'd1);
        send_cmd(FN_TICK, 7'd0, 7'd0);
        send_cmd(FN_NOTE_OFF, 7'd99, 7'd0);
        send_cmd(FN_NOTE_OFF, 7'd127, 7'd0);
        send_cmd(FN_NONE, 7'h7f, 7'h7f);
        send_cmd(FN_TICK, 7'd0, 7'd0);
        for (int i = 0; i < POOL; i++)
            send_cmd(FN_NOTE_ON, 7'(110 + i), 7'(127 - 9 * i));
        send_cmd(FN_TICK, 7'd0, 7'd0);
        send_cmd(FN_TICK, 7'd0, 7'd0);
        release_all();
    endtask

    task automatic test_config_extremes();
        program_mixer(15'd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_cmd(FN_TICK, 7'd0, 7'd0);
        send_cmd(FN_NOTE_ON, 7'd127, 7'd127);
        send_cmd(FN_NOTE_ON, 7'd120, 7'd127);
        repeat (5) send_cmd(FN_TICK, 7'd0, 7'd0);
        // inverted clamps
        program_mixer(15'd32767, -16'sd32768, 16'sd32767, 16'sd32767);
        repeat (3) send_cmd(FN_TICK, 7'd0, 7'd0);
        // zero amplitude still frees the same note
        program_mixer(15'd0, 16'sd0, 16'sd0, 16'sd32767);
        send_cmd(FN_NOTE_ON, 7'd127, 7'd127);
        send_cmd(FN_NOTE_ON, 7'd100, 7'd127);
        repeat (2) send_cmd(FN_TICK, 7'd0, 7'd0);
        release_all();
        send_cmd(FN_TICK, 7'd0, 7'd0);
    endtask

    task automatic test_backpressure();
        program_mixer(AMP_MAX_RST, CEIL_RST, FLOOR_RST, SILENCE_RST);
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = 600;
        for (int i = 0; i < 40; i++)
            if (i % 3 == 0)
                send_cmd(FN_NOTE_ON, 7'($urandom_range(100, 127)), 7'($urandom_range(1, 127)));
            else
                send_cmd(FN_TICK, 7'd0, 7'd0);
        drain();
        release_all();
    endtask

    task automatic test_random();
        int                issued;
        int                pick;
        int                slot;
        func_t             f;
        logic [NOTE_W-1:0] n;
        logic [VEL_W-1:0]  v;
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg)
                0: program_mixer(AMP_MAX_RST, CEIL_RST, FLOOR_RST, SILENCE_RST);
                1: program_mixer(15'd32767, 16'sd32767, -16'sd32768, -16'sd32768);
                2: program_mixer(15'($urandom), 16'($urandom_range(20000)),
                                 -16'($urandom_range(20000)), 16'($urandom));
                3: program_mixer(15'd32767, -16'sd32768, 16'sd32767, 16'sd32767);
                4: program_mixer(15'($urandom_range(1, 300)), 16'($urandom_range(200)),
                                 -16'($urandom_range(200)), 16'($urandom));
                6: program_mixer(15'd1000, 16'sd300, -16'sd300, 16'sd12345);
                default: program_mixer(15'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom));
            endcase
            case (seg % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 62; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 62; end
                default: begin sender_idle_pct = 10; stall_pct = 10; end
            endcase
            issued = 0;
            while (issued < SEG_ITEMS)
            begin
                pick = $urandom_range(99);
                n    = 7'($urandom_range(100, 127));
                v    = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 7'd127 : 7'd1)
                                                : 7'($urandom);
                if (pick < 45)
                    f = FN_TICK;
                else if (pick < 75)
                begin
                    f = FN_NOTE_ON;
                    if ($urandom_range(99) < 15)
                        n = 7'($urandom);
                    else if ($urandom_range(99) < 15 && |voice_on)
                    begin
                        slot = $urandom_range(POOL - 1);
                        while (!voice_on[slot])
                            slot = (slot + 1) % POOL;
                        n = voice_note[slot];
                    end
                end
                else if (pick < 93)
                begin
                    f = FN_NOTE_OFF;
                    if ($urandom_range(99) < 80 && |voice_on)
                    begin
                        slot = $urandom_range(POOL - 1);
                        while (!voice_on[slot])
                            slot = (slot + 1) % POOL;
                        n = voice_note[slot];
                    end
                    else
                        n = 7'($urandom);
                end
                else if (pick < 97)
                begin
                    f = FN_NONE;
                    n = 7'($urandom);
                end
                else
                begin
                    f = FN_NOTE_ON;
                    if ($urandom_range(1))
                        n = 7'd0;
                    else
                        v = 7'd0;
                end
                send_cmd(f, n, v);
                if (f != FN_NONE)
                    issued++;
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_data        = '0;
        mismatches      = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = 0;
        amp_max         = AMP_MAX_RST;
        ceil_lvl        = CEIL_RST;
        floor_lvl       = FLOOR_RST;
        silence_lvl     = SILENCE_RST;
        voice_on        = '0;
        for (int i = 0; i < POOL; i++)
        begin
            voice_note[i] = '0;
            voice_amp[i]  = '0;
            voice_lvl[i]  = '0;
            voice_half[i] = '0;
            voice_down[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        drain();

        if (mismatches == 0 && expected_mix.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
